// ===== src/oscillator_trim_search_top_assert.svh =====
// Assertion macros for the oscillator trim search block.
// Clocked property checks; empty when SYNTHESIS is defined.
`ifndef OSCILLATOR_TRIM_SEARCH_TOP_ASSERT_SVH
`define OSCILLATOR_TRIM_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// check with active-low reset masking
`define OTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds during reset
`define OTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define OTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define OTS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/ots_pkg.sv =====
// Package for the oscillator trim search block: widths, payload structs,
// phase type. No dependencies.
`timescale 1ns / 1ps

package ots_pkg;

    localparam int TRIM_BITS = 8;
    localparam int MEAS_BITS = 16;

    localparam logic [MEAS_BITS-1:0] TARGET_RESET = MEAS_BITS'(2356);
    localparam logic [TRIM_BITS-1:0] TRIM_MAX     = {TRIM_BITS{1'b1}};
    localparam logic [TRIM_BITS-1:0] STEP_FIRST   = TRIM_BITS'(1) << (TRIM_BITS - 1);

    // op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_MEAS  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SEARCH = 2'd1,
        PH_PROBE  = 2'd2
    } t_phase;

    typedef struct packed {
        logic                 op;
        logic [MEAS_BITS-1:0] measured_length;
    } t_in_item;

    typedef struct packed {
        logic [TRIM_BITS-1:0] trim_value;
        logic                 done_res;
    } t_out_item;

endpackage

// ===== src/oscillator_trim_search_top.sv =====
// Oscillator trim search: binary search on the trim, then a +/-1 probe.
// The result is registered in the cycle after the input transfer; one item per cycle while the output is not stalled.
// Throughput set by the single state update and the output register.
// Reset (i_rst_n low, synchronous): idle, no result pending, target 2356.
// Depends on ots_pkg and oscillator_trim_search_top_assert.svh.
`timescale 1ns / 1ps

`include "oscillator_trim_search_top_assert.svh"

module oscillator_trim_search_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // target length register
    input  logic                       i_cfg_we,
    input  logic [ots_pkg::MEAS_BITS-1:0] i_cfg_wdata,
    // command / measurement channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ots_pkg::t_in_item          i_in_data,
    // trim proposal channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ots_pkg::t_out_item         o_out_data
);
    import ots_pkg::*;

    // ------------------------------------------------------------------
    // Search state. Each accepted transfer updates it; the
    // proposed trim lands in the output register.
    // ------------------------------------------------------------------
    logic [MEAS_BITS-1:0] r_target;
    t_phase               r_phase,    n_phase;
    logic [TRIM_BITS-1:0] r_step,     n_step;
    logic [TRIM_BITS-1:0] r_trial,    n_trial;
    logic [TRIM_BITS-1:0] r_probe,    n_probe;
    logic [TRIM_BITS-1:0] r_best,     n_best;
    logic [MEAS_BITS-1:0] r_best_dev, n_best_dev;

    logic                 r_out_valid;
    t_out_item            r_out_data;

    logic                 w_accept;
    logic                 w_emit;
    t_out_item            w_emit_data;
    logic [TRIM_BITS-1:0] w_trial_keep;
    logic [TRIM_BITS-1:0] w_step_next;
    logic [TRIM_BITS-1:0] w_probe_last;
    logic [MEAS_BITS-1:0] w_dev;
    logic                 w_below;

    // Stall only when the result slot is full and not being drained, so a
    // new transfer is taken in the same cycle the old result leaves.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_below      = i_in_data.measured_length < r_target;
    assign w_dev        = w_below ? (r_target - i_in_data.measured_length)
                                  : (i_in_data.measured_length - r_target);
    assign w_trial_keep = w_below ? (r_trial + r_step) : r_trial;
    assign w_step_next  = r_step >> 1;
    // last probe, clipped at the top of the trim range
    assign w_probe_last = (r_trial < TRIM_MAX) ? (r_trial + TRIM_BITS'(1)) : r_trial;

    always_comb begin
        n_phase     = r_phase;
        n_step      = r_step;
        n_trial     = r_trial;
        n_probe     = r_probe;
        n_best      = r_best;
        n_best_dev  = r_best_dev;
        w_emit      = 1'b0;
        w_emit_data = '0;

        if (i_in_data.op == OP_START) begin
            // start restarts from any phase
            n_phase                = PH_SEARCH;
            n_step                 = STEP_FIRST;
            n_trial                = '0;
            n_probe                = '0;
            w_emit                 = 1'b1;
            w_emit_data.trim_value = STEP_FIRST;
        end else begin
            unique case (r_phase)
                PH_SEARCH: begin
                    n_trial = w_trial_keep;
                    n_step  = w_step_next;
                    w_emit  = 1'b1;
                    if (w_step_next != '0) begin
                        w_emit_data.trim_value = w_trial_keep + w_step_next;
                    end else begin
                        // search done: raw measurement seeds best deviation
                        n_best     = w_trial_keep;
                        n_best_dev = i_in_data.measured_length;
                        n_probe    = (w_trial_keep != '0) ? (w_trial_keep - TRIM_BITS'(1))
                                                          : w_trial_keep;
                        n_phase    = PH_PROBE;
                        w_emit_data.trim_value = n_probe;
                    end
                end
                PH_PROBE: begin
                    // strict compare: first trim wins ties
                    if (w_dev < r_best_dev) begin
                        n_best_dev = w_dev;
                        n_best     = r_probe;
                    end
                    w_emit = 1'b1;
                    if (r_probe < w_probe_last) begin
                        n_probe                = r_probe + TRIM_BITS'(1);
                        w_emit_data.trim_value = n_probe;
                    end else begin
                        n_phase                = PH_IDLE;
                        w_emit_data.trim_value = n_best;
                        w_emit_data.done_res   = 1'b1;
                    end
                end
                default: begin
                    // measurement with no search running: dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= TARGET_RESET;
            r_phase     <= PH_IDLE;
            r_step      <= '0;
            r_trial     <= '0;
            r_probe     <= '0;
            r_best      <= '0;
            r_best_dev  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_phase    <= n_phase;
                r_step     <= n_step;
                r_trial    <= n_trial;
                r_probe    <= n_probe;
                r_best     <= n_best;
                r_best_dev <= n_best_dev;
            end
            if (w_accept && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out_data <= w_emit_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `OTS_ASSERT(a_step_onehot, i_clk, i_rst_n, (r_phase == PH_SEARCH) |-> $onehot(r_step), "step bit not one-hot during search")
    `OTS_ASSERT(a_probe_range, i_clk, i_rst_n, (r_phase == PH_PROBE) |-> ((r_probe <= w_probe_last) && ((r_probe == r_trial) || (r_probe + TRIM_BITS'(1) == r_trial) || (r_probe == w_probe_last))), "probe outside trial neighborhood")
    `OTS_ASSERT(a_done_idle, i_clk, i_rst_n, (w_accept && w_emit && w_emit_data.done_res) |=> ((r_phase == PH_IDLE) && o_out_valid && o_out_data.done_res), "final trim without return to idle")

endmodule
